// File: hw/rtl/soie_pkg.sv
`default_nettype none
package soie_pkg;

	localparam int MAX_BYTES = 14;
	localparam int LEN_W     = 4;
	localparam int LINE_W    = 24;

	typedef logic [7:0] byte_t;

	// register indexes of the config port
	localparam logic CFG_DOUBLE_PREFIX = 1'b0;
	localparam logic CFG_QUAD_PREFIX   = 1'b1;

	typedef struct packed {
		byte_t [MAX_BYTES-1:0] bytes;
		logic [LEN_W-1:0]      len;
		logic [LINE_W-1:0]     line;
	} frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} frame_bus_t;

	// true when a 32-bit value survives truncation to 8 or 16 signed bits
	function automatic logic fits8(input logic [31:0] v);
		fits8 = (&v[31:7]) | ~(|v[31:7]);
	endfunction

	function automatic logic fits16(input logic [31:0] v);
		fits16 = (&v[31:15]) | ~(|v[31:15]);
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/soie_encoder.sv
`default_nettype none
module soie_encoder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [7:0]          cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          mode,
	input  wire logic [7:0]          opcode,
	input  wire logic [31:0]         operand_first,
	input  wire logic [31:0]         operand_second,
	input  wire logic [31:0]         operand_third,
	input  wire logic [23:0]         source_line,
	input  wire logic                frame_done,
	output soie_pkg::frame_bus_t     frame_bus
);

	typedef enum logic [1:0] {
		WIDTH_1,
		WIDTH_2,
		WIDTH_4
	} width_t;

	logic [7:0] double_prefix_q;
	logic [7:0] quad_prefix_q;

	logic              frame_valid_s1;
	soie_pkg::frame_t  frame_s1;
	soie_pkg::frame_t  frame_next;

	logic [1:0]  count;
	logic        use2;
	logic        use3;
	logic        all8;
	logic        all16;
	width_t      width;
	logic [31:0] ops [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_prefix_q <= 8'd0;
			quad_prefix_q   <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				soie_pkg::CFG_DOUBLE_PREFIX: double_prefix_q <= cfg_data;
				soie_pkg::CFG_QUAD_PREFIX:   quad_prefix_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ops[0] = operand_first;
	assign ops[1] = operand_second;
	assign ops[2] = operand_third;

	// mode zero counts as one operand
	assign count = (mode == 2'd0) ? 2'd1 : mode;
	assign use2  = (count != 2'd1);
	assign use3  = (count == 2'd3);

	assign all8  = soie_pkg::fits8(ops[0]) & (~use2 | soie_pkg::fits8(ops[1]))
		& (~use3 | soie_pkg::fits8(ops[2]));
	assign all16 = soie_pkg::fits16(ops[0]) & (~use2 | soie_pkg::fits16(ops[1]))
		& (~use3 | soie_pkg::fits16(ops[2]));

	always_comb begin
		if (all8)
			width = WIDTH_1;
		else if (all16)
			width = WIDTH_2;
		else
			width = WIDTH_4;
	end

	// bytes past len are never read
	always_comb begin
		frame_next       = '0;
		frame_next.line  = source_line;
		unique case (width)
			WIDTH_1: begin
				frame_next.bytes[0] = opcode;
				for (int i = 0; i < 3; i++)
					frame_next.bytes[1+i] = ops[i][7:0];
				frame_next.len = soie_pkg::LEN_W'(count) + soie_pkg::LEN_W'(1);
			end
			WIDTH_2: begin
				frame_next.bytes[0] = double_prefix_q;
				frame_next.bytes[1] = opcode;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 2; j++)
						frame_next.bytes[2+2*i+j] = ops[i][8*j +: 8];
				frame_next.len = {1'b0, count, 1'b0} + soie_pkg::LEN_W'(2);
			end
			default: begin
				frame_next.bytes[0] = quad_prefix_q;
				frame_next.bytes[1] = opcode;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 4; j++)
						frame_next.bytes[2+4*i+j] = ops[i][8*j +: 8];
				frame_next.len = {count, 2'b00} + soie_pkg::LEN_W'(2);
			end
		endcase
	end

	// a new word may land in the cycle the serializer takes the last byte
	assign in_ready = ~frame_valid_s1 | frame_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			frame_valid_s1 <= 1'b1;
		end else if (frame_done) begin
			frame_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			frame_s1 <= frame_next;
	end

	assign frame_bus.valid = frame_valid_s1;
	assign frame_bus.frame = frame_s1;

endmodule
`default_nettype wire

// File: hw/rtl/soie_serializer.sv
`default_nettype none
module soie_serializer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire soie_pkg::frame_bus_t frame_bus,
	output logic                     frame_done,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [7:0]               code_byte,
	output logic [23:0]              byte_line,
	output logic                     last_byte
);

	logic [soie_pkg::LEN_W-1:0] idx_q;
	logic                       out_valid_q;
	logic [7:0]                 byte_q;
	logic [23:0]                line_q;
	logic                       last_q;
	logic                       load;
	logic                       at_last;

	assign load    = frame_bus.valid & (~out_valid_q | out_ready);
	assign at_last = (idx_q == frame_bus.frame.len - soie_pkg::LEN_W'(1));
	assign frame_done = load & at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= at_last ? '0 : idx_q + soie_pkg::LEN_W'(1);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= frame_bus.frame.bytes[idx_q];
			line_q <= frame_bus.frame.line;
			last_q <= at_last;
		end
	end

	assign out_valid = out_valid_q;
	assign code_byte = byte_q;
	assign byte_line = line_q;
	assign last_byte = last_q;

	// read pointer stays inside the held frame
	assert property (@(posedge clk) disable iff (!arst_n)
		frame_bus.valid |-> idx_q < frame_bus.frame.len)
		else $error("byte index past frame length");

	// between frames the pointer sits at the first byte
	assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> idx_q == '0)
		else $error("byte index not rewound after last byte");

	// a stalled output word is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(byte_q) && $stable(last_q))
		else $error("held output byte changed");

	// every loaded byte is presented as an output word
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("loaded byte not presented");

endmodule
`default_nettype wire

// File: hw/rtl/scaled_operand_instruction_encoder_unit.sv
`default_nettype none
// an instruction's word is first registered as the held frame; its first byte then moves to the output register
// throughput: one output byte per cycle while m_axis_tready is high; an instruction is n bytes (2 to 14),
// drained one at a time from the held frame through the single byte-wide output register
// a new instruction is taken in the cycle its predecessor's last byte is loaded
// reset (arst_n low, asynchronous) empties the frame and output registers and sets the
// prefix registers to 0 (two-byte) and 1 (four-byte)
module scaled_operand_instruction_encoder_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [7:0]   cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// mode[1:0], opcode[9:2], operand_first[41:10], operand_second[73:42],
	// operand_third[105:74], source_line[129:106], zero[135:130]
	input  wire logic [135:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// code_byte[7:0], byte_line[31:8]
	output logic [31:0]       m_axis_tdata,
	output logic              m_axis_tlast
);

	soie_pkg::frame_bus_t frame_bus;
	logic                 frame_done;
	logic [7:0]           code_byte;
	logic [23:0]          byte_line;

	soie_encoder u_encoder (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.mode           (s_axis_tdata[1:0]),
		.opcode         (s_axis_tdata[9:2]),
		.operand_first  (s_axis_tdata[41:10]),
		.operand_second (s_axis_tdata[73:42]),
		.operand_third  (s_axis_tdata[105:74]),
		.source_line    (s_axis_tdata[129:106]),
		.frame_done     (frame_done),
		.frame_bus      (frame_bus)
	);

	soie_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_bus  (frame_bus),
		.frame_done (frame_done),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.code_byte  (code_byte),
		.byte_line  (byte_line),
		.last_byte  (m_axis_tlast)
	);

	assign m_axis_tdata = {byte_line, code_byte};

endmodule
`default_nettype wire

// File: sim/tb_top.sv
module tb_top;

	localparam int STALL_LIMIT = 600;

	typedef struct packed {
		logic [1:0]       mode;
		logic [7:0]       opcode;
		logic [2:0][31:0] operand;
		logic [23:0]      line;
	} instr_t;

	typedef struct packed {
		logic [7:0]  code;
		logic [23:0] line;
		logic        last;
	} code_word_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic         cfg_index = 1'b0;
	logic [7:0]   cfg_data = 8'h00;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// mode, opcode, operand_first, operand_second, operand_third, source_line, zero pad
	logic [135:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// code_byte, byte_line
	logic [31:0]  m_axis_tdata;
	logic         m_axis_tlast;

	scaled_operand_instruction_encoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	instr_t     pending_instrs[$];
	code_word_t expected_bytes[$];
	logic [7:0] double_code = 8'h00;
	logic [7:0] quad_code = 8'h01;
	bit         calm = 1'b0;
	int         mismatches = 0;
	int         instrs_sent = 0;
	int         bytes_seen = 0;
	int         settings_used = 1;
	int         wide_instrs = 0;

	function automatic void enqueue(instr_t it);
		pending_instrs.insert(pending_instrs.size(), it);
	endfunction

	function automatic int operand_span(logic [31:0] v);
		if ($signed(v) >= -128 && $signed(v) <= 127)
			return 1;
		if ($signed(v) >= -32768 && $signed(v) <= 32767)
			return 2;
		return 4;
	endfunction

	// expected byte sequence of one instruction
	function automatic void encode_bytes(instr_t it);
		logic [7:0] seq [14];
		int n;
		int count;
		int span;
		code_word_t w;
		n = 0;
		count = (it.mode == 2'd0) ? 1 : int'(it.mode);
		span = 1;
		for (int i = 0; i < count; i++)
			if (operand_span(it.operand[i]) > span)
				span = operand_span(it.operand[i]);
		if (span == 2) begin
			seq[n] = double_code;
			n++;
		end else if (span == 4) begin
			seq[n] = quad_code;
			n++;
		end
		seq[n] = it.opcode;
		n++;
		for (int i = 0; i < count; i++)
			for (int b = 0; b < span; b++) begin
				seq[n] = it.operand[i][8*b +: 8];
				n++;
			end
		if (n == 14)
			wide_instrs++;
		for (int k = 0; k < n; k++) begin
			w.code = seq[k];
			w.line = it.line;
			w.last = (k == n - 1);
			expected_bytes.insert(expected_bytes.size(), w);
		end
	endfunction

	function automatic logic [135:0] pack_instr(instr_t it);
		return {6'b0, it.line, it.operand[2], it.operand[1], it.operand[0],
			it.opcode, it.mode};
	endfunction

	function automatic instr_t make_instr(logic [1:0] mode, logic [7:0] opcode, logic [31:0] a,
			logic [31:0] b, logic [31:0] c, logic [23:0] line);
		instr_t it;
		it.mode = mode;
		it.opcode = opcode;
		it.operand[0] = a;
		it.operand[1] = b;
		it.operand[2] = c;
		it.line = line;
		return it;
	endfunction

	function automatic logic [31:0] corner_operand();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h0000_007f;
			3: return 32'hffff_ff80;
			4: return 32'h0000_0080;
			5: return 32'hffff_ff7f;
			6: return 32'h0000_7fff;
			7: return 32'hffff_8000;
			8: return 32'h0000_8000;
			9: return 32'hffff_7fff;
			10: return 32'h7fff_ffff;
			default: return 32'h8000_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_operand();
		int v;
		case ($urandom_range(0, 5))
			0: v = int'($urandom_range(0, 255)) - 128;
			1: v = int'($urandom_range(0, 65535)) - 32768;
			2: v = int'($urandom);
			3: v = int'(corner_operand());
			4: v = int'($urandom_range(0, 300));
			default: begin
				v = 32768 + int'($urandom_range(0, 3));
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic instr_t random_instr(bit echo_opcode);
		instr_t it;
		it.mode = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
		it.opcode = 8'($urandom);
		if (echo_opcode && $urandom_range(0, 1))
			it.opcode = double_code;
		for (int i = 0; i < 3; i++)
			it.operand[i] = pick_operand();
		it.line = 24'($urandom);
		return it;
	endfunction

	// input side: one instruction word per handshake
	instr_t cur_instr;
	int     send_hold = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				encode_bytes(cur_instr);
				instrs_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_hold == 0 && !calm && $urandom_range(0, 7) == 0)
					send_hold = $urandom_range(1, 14);
				if (send_hold > 0) begin
					send_hold--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_instrs.size() != 0) begin
					cur_instr = pending_instrs.pop_front();
					s_axis_tdata <= pack_instr(cur_instr);
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: compare each byte word with the oldest expectation
	int recv_hold = 0;

	always @(posedge clk) begin
		code_word_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				bytes_seen++;
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected word code %02h line %06h last %0b", $time,
						m_axis_tdata[7:0], m_axis_tdata[31:8], m_axis_tlast);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (m_axis_tdata[7:0] !== want.code || m_axis_tdata[31:8] !== want.line ||
							m_axis_tlast !== want.last) begin
						$display({"%0t: expected code %02h line %06h last %0b, ",
							"actual code %02h line %06h last %0b"},
							$time, want.code, want.line, want.last,
							m_axis_tdata[7:0], m_axis_tdata[31:8], m_axis_tlast);
						mismatches++;
					end
				end
			end
			if (recv_hold == 0 && !calm && $urandom_range(0, 7) == 0)
				recv_hold = $urandom_range(1, 14);
			if (recv_hold > 0) begin
				recv_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending_instrs.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_prefixes(logic [7:0] dbl, logic [7:0] quad);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= soie_pkg::CFG_DOUBLE_PREFIX;
		cfg_data <= dbl;
		@(posedge clk);
		cfg_index <= soie_pkg::CFG_QUAD_PREFIX;
		cfg_data <= quad;
		@(posedge clk);
		cfg_we <= 1'b0;
		double_code = dbl;
		quad_code = quad;
		settings_used++;
	endtask

	task automatic run_random(int n, bit echo_opcode);
		for (int i = 0; i < n; i++)
			enqueue(random_instr(echo_opcode));
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// width boundaries, field extremes, all operand counts
		enqueue(make_instr(2'd1, 8'h00, 32'h0, 32'h0, 32'h0, 24'h000000));
		enqueue(make_instr(2'd1, 8'hff, 32'h7f, 32'hffff_ffff, 32'h0, 24'hffffff));
		enqueue(make_instr(2'd1, 8'h10, 32'hffff_ff80, 32'h0, 32'h0, 24'h000001));
		enqueue(make_instr(2'd1, 8'h11, 32'h80, 32'h0, 32'h0, 24'h800000));
		enqueue(make_instr(2'd1, 8'h12, 32'hffff_ff7f, 32'h0, 32'h0, 24'h123456));
		enqueue(make_instr(2'd1, 8'h13, 32'h7fff, 32'h0, 32'h0, 24'h00ff00));
		enqueue(make_instr(2'd1, 8'h14, 32'hffff_8000, 32'h0, 32'h0, 24'h0000ff));
		enqueue(make_instr(2'd1, 8'h15, 32'h8000, 32'h0, 32'h0, 24'hff0000));
		enqueue(make_instr(2'd1, 8'h16, 32'hffff_7fff, 32'h0, 32'h0, 24'h555555));
		enqueue(make_instr(2'd1, 8'h17, 32'h7fff_ffff, 32'h0, 32'h0, 24'haaaaaa));
		enqueue(make_instr(2'd1, 8'h18, 32'h8000_0000, 32'h0, 32'h0, 24'h000002));
		enqueue(make_instr(2'd2, 8'h20, 32'h1, 32'd200, 32'h0, 24'h000003));
		enqueue(make_instr(2'd3, 8'h30, 32'd5, -32'sd7, 32'd70000, 24'h000004));
		enqueue(make_instr(2'd3, 8'h31, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 24'h000005));
		// longest encoding: prefix, opcode, three four-byte operands
		enqueue(make_instr(2'd3, 8'h32, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 24'hfffffe));
		// mode zero behaves as one operand
		enqueue(make_instr(2'd0, 8'h40, 32'd300, 32'h7fff_ffff, 32'h8000_0000,
			24'h000006));
		enqueue(make_instr(2'd0, 8'h41, 32'd3, 32'h0, 32'h0, 24'h000007));
		// operands past the count must not widen the encoding
		enqueue(make_instr(2'd1, 8'h42, 32'd5, 32'h8000_0000, 32'h7fff_ffff,
			24'h000008));
		enqueue(make_instr(2'd2, 8'h43, 32'hffff_fff0, 32'd100, 32'h1234_5678,
			24'h000009));
		// prefix values that collide with the opcode
		enqueue(make_instr(2'd1, 8'h01, 32'd100000, 32'h0, 32'h0, 24'h00000a));
		enqueue(make_instr(2'd2, 8'h00, 32'd1000, 32'd2, 32'h0, 24'h00000b));
		drain();
		run_random(40, 1'b0);

		set_prefixes(8'hff, 8'h00);
		run_random(50, 1'b0);
		set_prefixes(8'($urandom), 8'($urandom));
		run_random(50, 1'b0);
		set_prefixes(8'h00, 8'hff);
		run_random(50, 1'b0);
		set_prefixes(8'h3c, 8'h3c);
		run_random(30, 1'b1);

		// closing stretch with both sides always ready
		calm = 1'b1;
		set_prefixes(8'($urandom), 8'($urandom));
		run_random(50, 1'b0);
		repeat (12) @(posedge clk);

		$display("tb: %0d instructions, %0d bytes checked, %0d of maximum length",
			instrs_sent, bytes_seen, wide_instrs);
		$display("tb: %0d prefix settings used, %0d mismatches", settings_used, mismatches);
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/soie_pkg.sv
hw/rtl/soie_encoder.sv
hw/rtl/soie_serializer.sv
hw/rtl/scaled_operand_instruction_encoder_unit.sv
sim/tb_top.sv
